// ===== hdl/tdsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tdsm_pkg
// Types and constants shared by the table-driven state machine engine.
// ----------------------------------------------------------------------------
package tdsm_pkg;

  localparam int STATE_W = 4;
  localparam int EVENT_W = 4;
  localparam int LIMIT_W = 5;
  localparam int CMD_W   = 2;
  localparam int CFGI_W  = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // Configuration register indexes.
  localparam logic [CFGI_W-1:0] CFG_INITIAL_STATE = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_STATES_IN_USE = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_EVENTS_IN_USE = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPLY     = 2'd0,
    CMD_ADD_TRANS = 2'd1,
    CMD_ADD_STATE = 2'd2,
    CMD_RESTART   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_LOOK,
    SEQ_ENTRY,
    SEQ_HOLD
  } seq_state_t;

  typedef struct packed {
    logic [STATE_W-1:0] start_state;
    logic [LIMIT_W-1:0] states_in_use;
    logic [LIMIT_W-1:0] events_in_use;
  } cfg_t;

  typedef struct packed {
    logic               defined;
    logic [STATE_W-1:0] target;
    logic               action;
  } trans_entry_t;

  typedef struct packed {
    logic entry_act;
    logic exit_act;
  } state_act_t;

  typedef struct packed {
    logic defined;
    logic entry_act;
    logic exit_act;
  } state_rec_t;

  typedef struct packed {
    logic               status;
    logic               took_transition;
    logic               fire_exit;
    logic               fire_transition;
    logic               fire_entry;
    logic [STATE_W-1:0] previous_state;
    logic [STATE_W-1:0] current_state;
    logic [EVENT_W-1:0] latest_event;
    logic               latest_event_valid;
  } result_t;

endpackage

// ===== hdl/tdsm_trans_mem.sv =====
// ----------------------------------------------------------------------------
// tdsm_trans_mem
// Transition table memory with a registered read port and a clearing pass
// after reset that zeroes every entry, one per cycle.
// ----------------------------------------------------------------------------
module tdsm_trans_mem #(
  parameter int TABLE_SIZE = 256,
  parameter int TAW        = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  output logic                    clearing,
  input  logic [TAW-1:0]          rd_addr,
  output tdsm_pkg::trans_entry_t  rd_data,
  input  logic                    wr_en,
  input  logic [TAW-1:0]          wr_addr,
  input  tdsm_pkg::trans_entry_t  wr_data
);
  import tdsm_pkg::*;

  localparam logic [TAW-1:0] LAST_ADDR = TAW'(TABLE_SIZE - 1);

  trans_entry_t   mem [TABLE_SIZE];
  logic [TAW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/tdsm_state_store.sv =====
// ----------------------------------------------------------------------------
// tdsm_state_store
// Per-state action flags in a synchronous memory, with a defined bit per
// state in flip-flops. An undefined state reads as having no actions.
// ----------------------------------------------------------------------------
module tdsm_state_store #(
  parameter int STATE_SLOTS = 16,
  parameter int SAW         = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [SAW-1:0]        rd_addr,
  output tdsm_pkg::state_rec_t  rd_data,
  input  logic                  wr_en,
  input  logic [SAW-1:0]        wr_addr,
  input  tdsm_pkg::state_act_t  wr_data
);
  import tdsm_pkg::*;

  state_act_t             act_mem [STATE_SLOTS];
  logic [STATE_SLOTS-1:0] defined;
  state_act_t             rd_act;
  logic                   rd_def;

  always_ff @(posedge clk) begin
    if (rst) begin
      defined <= '0;
    end else if (wr_en) begin
      defined[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      act_mem[wr_addr] <= wr_data;
    end
    rd_act <= act_mem[rd_addr];
    rd_def <= defined[rd_addr];
  end

  // Memory contents may be stale from before reset, so mask by the defined bit.
  assign rd_data.defined   = rd_def;
  assign rd_data.entry_act = rd_def & rd_act.entry_act;
  assign rd_data.exit_act  = rd_def & rd_act.exit_act;

endmodule

// ===== hdl/tdsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdsm_ctrl
// Command sequencer: issues table reads, checks limits and duplicates,
// writes back definitions, updates the present state and holds the result.
// ----------------------------------------------------------------------------
module tdsm_ctrl #(
  parameter int STATE_SLOTS = 16,
  parameter int EVENT_SLOTS = 16,
  parameter int TAW         = 8,
  parameter int SAW         = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tdsm_pkg::cfg_t                    cfg,
  input  logic                              clearing,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tdsm_pkg::cmd_t                    in_cmd,
  input  logic [tdsm_pkg::EVENT_W-1:0]      in_event,
  input  logic [tdsm_pkg::STATE_W-1:0]      in_state,
  input  logic [tdsm_pkg::STATE_W-1:0]      in_next,
  input  logic                              in_t_act,
  input  logic                              in_en_act,
  input  logic                              in_ex_act,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tdsm_pkg::result_t                 out_res,
  output logic [TAW-1:0]                    tr_rd_addr,
  input  tdsm_pkg::trans_entry_t            tr_rd_data,
  output logic                              tr_wr_en,
  output logic [TAW-1:0]                    tr_wr_addr,
  output tdsm_pkg::trans_entry_t            tr_wr_data,
  output logic [SAW-1:0]                    st_rd_addr,
  input  tdsm_pkg::state_rec_t              st_rd_data,
  output logic                              st_wr_en,
  output logic [SAW-1:0]                    st_wr_addr,
  output tdsm_pkg::state_act_t              st_wr_data
);
  import tdsm_pkg::*;

  seq_state_t          seq, seq_next;
  logic [STATE_W-1:0]  present_state, present_state_next;
  logic [EVENT_W-1:0]  recent_event, recent_event_next;
  logic                recent_event_valid, recent_event_valid_next;

  // Captured transaction.
  cmd_t                r_cmd;
  logic [EVENT_W-1:0]  r_event;
  logic [STATE_W-1:0]  r_state;
  logic [STATE_W-1:0]  r_next;
  logic                r_tact;
  logic                r_enact;
  logic                r_exact;
  logic [TAW-1:0]      r_idx;
  logic                r_ps_in;

  // Saved across the second state-memory read.
  logic [STATE_W-1:0]  r_tgt;
  logic                r_fire_tr;
  logic                r_fire_exit;

  result_t             res, res_next;
  logic                accept;
  logic                finish;
  logic                save_look;
  logic                out_free;
  logic                out_load;
  result_t             out_load_data;
  logic [STATE_W-1:0]  idx_state;
  logic                ev_ok;
  logic                st_ok;
  logic                nx_ok;

  assign in_ready = (seq == SEQ_IDLE) && !clearing;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign ev_ok = ({1'b0, r_event} < cfg.events_in_use) && (32'(r_event) < 32'(EVENT_SLOTS));
  assign st_ok = ({1'b0, r_state} < cfg.states_in_use) && (32'(r_state) < 32'(STATE_SLOTS));
  assign nx_ok = ({1'b0, r_next} < cfg.states_in_use) && (32'(r_next) < 32'(STATE_SLOTS));

  assign idx_state  = (in_cmd == CMD_APPLY) ? present_state : in_state;
  assign tr_rd_addr = TAW'(32'(idx_state) * 32'(EVENT_SLOTS) + 32'(in_event));

  assign tr_wr_addr         = r_idx;
  assign tr_wr_data.defined = 1'b1;
  assign tr_wr_data.target  = r_next;
  assign tr_wr_data.action  = r_tact;
  assign st_wr_addr           = SAW'(r_state);
  assign st_wr_data.entry_act = r_enact;
  assign st_wr_data.exit_act  = r_exact;

  always_comb begin
    logic status;
    logic took;
    logic f_exit;
    logic f_tr;
    logic f_entry;
    seq_next                = seq;
    present_state_next      = present_state;
    recent_event_next       = recent_event;
    recent_event_valid_next = recent_event_valid;
    status    = 1'b0;
    took      = 1'b0;
    f_exit    = 1'b0;
    f_tr      = 1'b0;
    f_entry   = 1'b0;
    finish    = 1'b0;
    save_look = 1'b0;
    tr_wr_en  = 1'b0;
    st_wr_en  = 1'b0;
    st_rd_addr = SAW'(idx_state);

    unique case (seq)
      SEQ_IDLE: begin
        if (accept) begin
          seq_next = SEQ_LOOK;
        end
      end
      SEQ_LOOK: begin
        // Fetch the target's entry flag in case the state really changes.
        st_rd_addr = SAW'(tr_rd_data.target);
        finish     = 1'b1;
        unique case (r_cmd)
          CMD_APPLY: begin
            if (!ev_ok) begin
              status = 1'b1;
            end else if (r_ps_in && tr_rd_data.defined) begin
              took = 1'b1;
              f_tr = tr_rd_data.action;
              if (tr_rd_data.target != present_state) begin
                finish    = 1'b0;
                save_look = 1'b1;
                seq_next  = SEQ_ENTRY;
              end
            end
          end
          CMD_ADD_TRANS: begin
            if (!st_ok || !ev_ok || !nx_ok || tr_rd_data.defined) begin
              status = 1'b1;
            end else begin
              tr_wr_en = 1'b1;
            end
          end
          CMD_ADD_STATE: begin
            if (!st_ok || st_rd_data.defined) begin
              status = 1'b1;
            end else begin
              st_wr_en = 1'b1;
            end
          end
          CMD_RESTART: begin
            present_state_next      = cfg.start_state;
            recent_event_next       = '0;
            recent_event_valid_next = 1'b0;
          end
          default: begin
            status = 1'b1;
          end
        endcase
      end
      SEQ_ENTRY: begin
        finish                  = 1'b1;
        took                    = 1'b1;
        f_tr                    = r_fire_tr;
        f_exit                  = r_fire_exit;
        f_entry                 = st_rd_data.entry_act;
        present_state_next      = r_tgt;
        recent_event_next       = r_event;
        recent_event_valid_next = 1'b1;
      end
      SEQ_HOLD: begin
        if (out_free) begin
          seq_next = SEQ_IDLE;
        end
      end
      default: begin
        seq_next = SEQ_IDLE;
      end
    endcase

    if (finish) begin
      seq_next = out_free ? SEQ_IDLE : SEQ_HOLD;
    end

    res_next.status             = status;
    res_next.took_transition    = took;
    res_next.fire_exit          = f_exit;
    res_next.fire_transition    = f_tr;
    res_next.fire_entry         = f_entry;
    res_next.previous_state     = present_state;
    res_next.current_state      = present_state_next;
    res_next.latest_event       = recent_event_next;
    res_next.latest_event_valid = recent_event_valid_next;
  end

  assign out_load      = (finish || (seq == SEQ_HOLD)) && out_free;
  assign out_load_data = finish ? res_next : res;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq                <= SEQ_IDLE;
      present_state      <= '0;
      recent_event       <= '0;
      recent_event_valid <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      seq                <= seq_next;
      present_state      <= present_state_next;
      recent_event       <= recent_event_next;
      recent_event_valid <= recent_event_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_cmd   <= in_cmd;
      r_event <= in_event;
      r_state <= in_state;
      r_next  <= in_next;
      r_tact  <= in_t_act;
      r_enact <= in_en_act;
      r_exact <= in_ex_act;
      r_idx   <= tr_rd_addr;
      r_ps_in <= 32'(present_state) < 32'(STATE_SLOTS);
    end
    if (save_look) begin
      r_tgt       <= tr_rd_data.target;
      r_fire_tr   <= tr_rd_data.action;
      r_fire_exit <= st_rd_data.exit_act;
    end
    if (finish) begin
      res <= res_next;
    end
    if (out_load) begin
      out_res <= out_load_data;
    end
  end

endmodule

// ===== hdl/table_driven_state_machine.sv =====
// ----------------------------------------------------------------------------
// table_driven_state_machine
// Programmable state machine engine with a write-once transition table and
// per-state entry and exit action flags kept in synchronous memories.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake               Payload
//   input    in_valid / in_ready     cmd, event_req, state, target_state, has_*
//   output   out_valid / out_ready   status, fire flags, states, latest_event*
//   config   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One transaction is in work at a time. Most commands are accepted in SEQ_IDLE
// and reach the result register from SEQ_LOOK; an event that changes the
// state goes on through SEQ_ENTRY, for a second read of the state memory.
// With a result waiting for out_ready, the next transaction is still taken and
// its result parks in the controller; the one after it waits for the output.
// After reset the transition memory clears all STATE_SLOTS * EVENT_SLOTS
// entries while in_ready is low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module table_driven_state_machine #(
  parameter int STATE_SLOTS = 16,
  parameter int EVENT_SLOTS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tdsm_pkg::CMD_W-1:0]     cmd,
  input  logic [tdsm_pkg::EVENT_W-1:0]   event_req,
  input  logic [tdsm_pkg::STATE_W-1:0]   state,
  input  logic [tdsm_pkg::STATE_W-1:0]   target_state,
  input  logic                           has_transition_action,
  input  logic                           has_entry_action,
  input  logic                           has_exit_action,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           status,
  output logic                           took_transition,
  output logic                           fire_exit,
  output logic                           fire_transition,
  output logic                           fire_entry,
  output logic [tdsm_pkg::STATE_W-1:0]   previous_state,
  output logic [tdsm_pkg::STATE_W-1:0]   current_state,
  output logic [tdsm_pkg::EVENT_W-1:0]   latest_event,
  output logic                           latest_event_valid,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tdsm_pkg::CFGI_W-1:0]    cfg_index,
  input  logic [tdsm_pkg::LIMIT_W-1:0]   cfg_data
);
  import tdsm_pkg::*;

  localparam int TABLE_SIZE = STATE_SLOTS * EVENT_SLOTS;
  localparam int TAW        = $clog2(TABLE_SIZE);
  localparam int SAW        = $clog2(STATE_SLOTS);

  cfg_t           cfg;
  logic           clearing;
  result_t        out_res;
  logic [TAW-1:0] tr_rd_addr;
  trans_entry_t   tr_rd_data;
  logic           tr_wr_en;
  logic [TAW-1:0] tr_wr_addr;
  trans_entry_t   tr_wr_data;
  logic [SAW-1:0] st_rd_addr;
  state_rec_t     st_rd_data;
  logic           st_wr_en;
  logic [SAW-1:0] st_wr_addr;
  state_act_t     st_wr_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_state   <= '0;
      cfg.states_in_use <= LIMIT_RESET;
      cfg.events_in_use <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INITIAL_STATE: cfg.start_state   <= cfg_data[STATE_W-1:0];
        CFG_STATES_IN_USE: cfg.states_in_use <= cfg_data;
        CFG_EVENTS_IN_USE: cfg.events_in_use <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tdsm_trans_mem #(
    .TABLE_SIZE (TABLE_SIZE),
    .TAW        (TAW)
  ) u_trans_mem (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .rd_addr  (tr_rd_addr),
    .rd_data  (tr_rd_data),
    .wr_en    (tr_wr_en),
    .wr_addr  (tr_wr_addr),
    .wr_data  (tr_wr_data)
  );

  tdsm_state_store #(
    .STATE_SLOTS (STATE_SLOTS),
    .SAW         (SAW)
  ) u_state_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data)
  );

  tdsm_ctrl #(
    .STATE_SLOTS (STATE_SLOTS),
    .EVENT_SLOTS (EVENT_SLOTS),
    .TAW         (TAW),
    .SAW         (SAW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .clearing   (clearing),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (cmd_t'(cmd)),
    .in_event   (event_req),
    .in_state   (state),
    .in_next    (target_state),
    .in_t_act   (has_transition_action),
    .in_en_act  (has_entry_action),
    .in_ex_act  (has_exit_action),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res),
    .tr_rd_addr (tr_rd_addr),
    .tr_rd_data (tr_rd_data),
    .tr_wr_en   (tr_wr_en),
    .tr_wr_addr (tr_wr_addr),
    .tr_wr_data (tr_wr_data),
    .st_rd_addr (st_rd_addr),
    .st_rd_data (st_rd_data),
    .st_wr_en   (st_wr_en),
    .st_wr_addr (st_wr_addr),
    .st_wr_data (st_wr_data)
  );

  assign status             = out_res.status;
  assign took_transition    = out_res.took_transition;
  assign fire_exit          = out_res.fire_exit;
  assign fire_transition    = out_res.fire_transition;
  assign fire_entry         = out_res.fire_entry;
  assign previous_state     = out_res.previous_state;
  assign current_state      = out_res.current_state;
  assign latest_event       = out_res.latest_event;
  assign latest_event_valid = out_res.latest_event_valid;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the table-driven state machine engine. A queue of
// commands feeds a driver that idles at random. A monitor predicts every
// result from its own copy of the tables, the registers and the present
// state, and compares each result field by field. A few directed commands
// cover the range checks, duplicate definitions, self-loops, undefined
// targets and restart. Several random phases follow, most with their own
// register settings, separated by idle points where the registers are written.
// ----------------------------------------------------------------------------
module tb_top;
  import tdsm_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int ENGINE_STATES = 16;
  localparam int ENGINE_EVENTS = 16;

  typedef struct packed {
    cmd_t               op;
    logic [EVENT_W-1:0] ev;
    logic [STATE_W-1:0] st;
    logic [STATE_W-1:0] nx;
    logic               t_act;
    logic               en_act;
    logic               ex_act;
  } cmd_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     cmd = '0;
  logic [EVENT_W-1:0]   event_req = '0;
  logic [STATE_W-1:0]   state = '0;
  logic [STATE_W-1:0]   target_state = '0;
  logic                 has_transition_action = 1'b0;
  logic                 has_entry_action = 1'b0;
  logic                 has_exit_action = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 status;
  logic                 took_transition;
  logic                 fire_exit;
  logic                 fire_transition;
  logic                 fire_entry;
  logic [STATE_W-1:0]   previous_state;
  logic [STATE_W-1:0]   current_state;
  logic [EVENT_W-1:0]   latest_event;
  logic                 latest_event_valid;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFGI_W-1:0]    cfg_index = '0;
  logic [LIMIT_W-1:0]   cfg_data = '0;

  table_driven_state_machine dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Handshake flags sampled at the rising edge, read at the falling edge.
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  logic cfg_taken = 1'b0;
  bit   steady = 1'b0;

  cmd_item_t command_queue[$];
  result_t   engine_outcomes[$];
  int        commands_sent = 0;
  int        commands_taken = 0;
  int        results_checked = 0;
  int        delivered = 0;
  int        mismatches = 0;
  int        followed = 0;
  int        state_changes = 0;
  int        rejected = 0;

  // Predictor copy of the engine.
  logic [STATE_W-1:0] reg_init;
  logic [LIMIT_W-1:0] reg_states;
  logic [LIMIT_W-1:0] reg_events;
  logic [STATE_W-1:0] eng_state;
  logic [EVENT_W-1:0] eng_event;
  logic               eng_event_ok;
  logic               trans_defined [ENGINE_STATES*ENGINE_EVENTS];
  logic [STATE_W-1:0] trans_target [ENGINE_STATES*ENGINE_EVENTS];
  logic               trans_act [ENGINE_STATES*ENGINE_EVENTS];
  logic               state_known [ENGINE_STATES];
  logic               entry_flag [ENGINE_STATES];
  logic               exit_flag [ENGINE_STATES];

  function automatic result_t advance_engine(input cmd_item_t c);
    result_t            r;
    logic [LIMIT_W-1:0] s_lim;
    logic [LIMIT_W-1:0] e_lim;
    logic [7:0]         idx;
    logic [STATE_W-1:0] tgt;
    s_lim = (reg_states < ENGINE_STATES) ? reg_states : LIMIT_W'(ENGINE_STATES);
    e_lim = (reg_events < ENGINE_EVENTS) ? reg_events : LIMIT_W'(ENGINE_EVENTS);
    r = '0;
    r.previous_state = eng_state;
    case (c.op)
      CMD_APPLY: begin
        idx = {eng_state, c.ev};
        if (c.ev >= e_lim) begin
          r.status = 1'b1;
        end else if (trans_defined[idx]) begin
          tgt = trans_target[idx];
          r.took_transition = 1'b1;
          r.fire_transition = trans_act[idx];
          // A self-loop signals only the transition action.
          if (tgt != eng_state) begin
            r.fire_exit = exit_flag[eng_state];
            r.fire_entry = entry_flag[tgt];
            eng_event = c.ev;
            eng_event_ok = 1'b1;
          end
          eng_state = tgt;
        end
      end
      CMD_ADD_TRANS: begin
        idx = {c.st, c.ev};
        if (c.st >= s_lim || c.ev >= e_lim || c.nx >= s_lim || trans_defined[idx]) begin
          r.status = 1'b1;
        end else begin
          trans_defined[idx] = 1'b1;
          trans_target[idx] = c.nx;
          trans_act[idx] = c.t_act;
        end
      end
      CMD_ADD_STATE: begin
        if (c.st >= s_lim || state_known[c.st]) begin
          r.status = 1'b1;
        end else begin
          state_known[c.st] = 1'b1;
          entry_flag[c.st] = c.en_act;
          exit_flag[c.st] = c.ex_act;
        end
      end
      default: begin
        eng_state = reg_init;
        eng_event = '0;
        eng_event_ok = 1'b0;
      end
    endcase
    r.current_state = eng_state;
    r.latest_event = eng_event;
    r.latest_event_valid = eng_event_ok;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch in %s of result %0d: expected %0d, got %0d",
                 name, results_checked, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t   want;
    cmd_item_t seen;
    int        i;
    if (rst) begin
      in_taken <= 1'b0;
      out_taken <= 1'b0;
      cfg_taken <= 1'b0;
      reg_init = '0;
      reg_states = LIMIT_RESET;
      reg_events = LIMIT_RESET;
      eng_state = '0;
      eng_event = '0;
      eng_event_ok = 1'b0;
      for (i = 0; i < ENGINE_STATES*ENGINE_EVENTS; i++) begin
        trans_defined[i] = 1'b0;
        trans_target[i] = '0;
        trans_act[i] = 1'b0;
      end
      for (i = 0; i < ENGINE_STATES; i++) begin
        state_known[i] = 1'b0;
        entry_flag[i] = 1'b0;
        exit_flag[i] = 1'b0;
      end
    end else begin
      in_taken <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
      cfg_taken <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INITIAL_STATE: reg_init = cfg_data[STATE_W-1:0];
          CFG_STATES_IN_USE: reg_states = cfg_data;
          CFG_EVENTS_IN_USE: reg_events = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        seen.op = cmd_t'(cmd);
        seen.ev = event_req;
        seen.st = state;
        seen.nx = target_state;
        seen.t_act = has_transition_action;
        seen.en_act = has_entry_action;
        seen.ex_act = has_exit_action;
        engine_outcomes.push_back(advance_engine(seen));
        commands_taken++;
      end
      if (out_valid && out_ready) begin
        if (engine_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result arrived with no command waiting for one");
        end else begin
          want = engine_outcomes.pop_front();
          results_checked++;
          check_field("status", 8'(want.status), 8'(status));
          check_field("took_transition", 8'(want.took_transition), 8'(took_transition));
          check_field("fire_exit", 8'(want.fire_exit), 8'(fire_exit));
          check_field("fire_transition", 8'(want.fire_transition), 8'(fire_transition));
          check_field("fire_entry", 8'(want.fire_entry), 8'(fire_entry));
          check_field("previous_state", 8'(want.previous_state), 8'(previous_state));
          check_field("current_state", 8'(want.current_state), 8'(current_state));
          check_field("latest_event", 8'(want.latest_event), 8'(latest_event));
          check_field("latest_event_valid", 8'(want.latest_event_valid),
                      8'(latest_event_valid));
          if (want.took_transition) followed++;
          if (want.took_transition && want.previous_state != want.current_state)
            state_changes++;
          if (want.status) rejected++;
        end
      end
    end
  end

  // Command driver: a new transaction only after the last one was accepted.
  always @(negedge clk) begin : feed
    cmd_item_t next_cmd;
    int        gap;
    if (rst) begin
      in_valid <= 1'b0;
      gap = 0;
    end else if (!in_valid || in_taken) begin
      if (gap != 0) begin
        in_valid <= 1'b0;
        gap--;
      end else if (command_queue.size() != 0) begin
        next_cmd = command_queue.pop_front();
        cmd <= next_cmd.op;
        event_req <= next_cmd.ev;
        state <= next_cmd.st;
        target_state <= next_cmd.nx;
        has_transition_action <= next_cmd.t_act;
        has_entry_action <= next_cmd.en_act;
        has_exit_action <= next_cmd.ex_act;
        in_valid <= 1'b1;
        gap = steady ? 0 : $urandom_range(0, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver. Twice in the run it holds off long enough for the
  // engine to back up and stall its command input.
  always @(negedge clk) begin : drain
    int hold;
    if (rst) begin
      out_ready <= 1'b0;
      hold = 0;
    end else if (out_taken) begin
      delivered++;
      hold = steady ? 0 : $urandom_range(0, 6);
      if (delivered == 300 || delivered == 1200) hold = 90;
      if (hold == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        hold--;
      end
    end else if (hold != 0) begin
      out_ready <= 1'b0;
      hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if (rst || in_taken || out_taken || cfg_taken) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic cmd_item_t command(input cmd_t op, input int ev, input int st,
                                        input int nx, input bit t, input bit en,
                                        input bit ex);
    cmd_item_t c;
    c.op = op;
    c.ev = ev[EVENT_W-1:0];
    c.st = st[STATE_W-1:0];
    c.nx = nx[STATE_W-1:0];
    c.t_act = t;
    c.en_act = en;
    c.ex_act = ex;
    return c;
  endfunction

  task automatic queue_command(input cmd_item_t c);
    command_queue.push_back(c);
    commands_sent++;
  endtask

  task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_registers(input logic [STATE_W-1:0] init, input logic [LIMIT_W-1:0] n_states,
                               input logic [LIMIT_W-1:0] n_events);
    write_reg(CFG_INITIAL_STATE, {1'b0, init});
    write_reg(CFG_STATES_IN_USE, n_states);
    write_reg(CFG_EVENTS_IN_USE, n_events);
  endtask

  // Returns once every queued command has been taken and answered, and then
  // lets the engine settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (commands_taken != commands_sent || engine_outcomes.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_random(input logic [STATE_W-1:0] init, input logic [LIMIT_W-1:0] n_states,
                            input logic [LIMIT_W-1:0] n_events, input bit no_gaps,
                            input int count);
    cmd_item_t c;
    int        pick;
    int        i;
    set_registers(init, n_states, n_events);
    steady <= no_gaps;
    @(posedge clk);
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 58) c.op = CMD_APPLY;
      else if (pick < 80) c.op = CMD_ADD_TRANS;
      else if (pick < 90) c.op = CMD_ADD_STATE;
      else c.op = CMD_RESTART;
      // Low event numbers dominate so that the table fills where it is used.
      c.ev = EVENT_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) :
                      $urandom_range(0, 15));
      c.st = STATE_W'((n_states != 0 && $urandom_range(0, 4) != 0) ?
                      $urandom_range(0, n_states - 1) : $urandom_range(0, 15));
      c.nx = STATE_W'((n_states != 0 && $urandom_range(0, 4) != 0) ?
                      $urandom_range(0, n_states - 1) : $urandom_range(0, 15));
      c.t_act = 1'($urandom_range(0, 1));
      c.en_act = 1'($urandom_range(0, 1));
      c.ex_act = 1'($urandom_range(0, 1));
      queue_command(c);
    end
    wait_idle();
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Full-size tables, starting in state 0.
    set_registers(4'd0, 5'd16, 5'd16);
    @(posedge clk);
    queue_command(command(CMD_APPLY, 0, 0, 0, 0, 0, 0));
    queue_command(command(CMD_ADD_STATE, 0, 0, 0, 0, 1, 1));
    queue_command(command(CMD_ADD_STATE, 0, 15, 0, 0, 1, 0));
    queue_command(command(CMD_ADD_STATE, 0, 0, 0, 0, 0, 0));
    queue_command(command(CMD_ADD_TRANS, 0, 0, 15, 1, 0, 0));
    queue_command(command(CMD_ADD_TRANS, 15, 0, 0, 0, 0, 0));
    queue_command(command(CMD_ADD_TRANS, 0, 0, 3, 0, 0, 0));
    queue_command(command(CMD_ADD_TRANS, 15, 15, 15, 1, 1, 1));
    queue_command(command(CMD_ADD_TRANS, 3, 15, 7, 0, 0, 0));
    queue_command(command(CMD_APPLY, 0, 0, 0, 0, 0, 0));
    queue_command(command(CMD_APPLY, 15, 0, 0, 0, 0, 0));
    queue_command(command(CMD_APPLY, 3, 0, 0, 0, 0, 0));
    queue_command(command(CMD_APPLY, 5, 0, 0, 0, 0, 0));
    queue_command(command(CMD_RESTART, 0, 0, 0, 0, 0, 0));
    queue_command(command(CMD_APPLY, 15, 0, 0, 0, 0, 0));
    wait_idle();

    // Narrow limits; the new initial state only shows after the restart.
    set_registers(4'd3, 5'd4, 5'd4);
    @(posedge clk);
    queue_command(command(CMD_APPLY, 4, 0, 0, 0, 0, 0));
    queue_command(command(CMD_APPLY, 0, 0, 0, 0, 0, 0));
    queue_command(command(CMD_ADD_STATE, 0, 4, 0, 0, 1, 1));
    queue_command(command(CMD_ADD_TRANS, 1, 1, 4, 1, 0, 0));
    queue_command(command(CMD_ADD_TRANS, 4, 1, 1, 1, 0, 0));
    queue_command(command(CMD_ADD_TRANS, 3, 3, 3, 1, 0, 0));
    queue_command(command(CMD_RESTART, 0, 0, 0, 0, 0, 0));
    queue_command(command(CMD_APPLY, 3, 0, 0, 0, 0, 0));
    wait_idle();

    // Zero limits reject every number.
    set_registers(4'd15, 5'd0, 5'd0);
    @(posedge clk);
    queue_command(command(CMD_ADD_STATE, 0, 0, 0, 0, 1, 1));
    queue_command(command(CMD_APPLY, 0, 0, 0, 0, 0, 0));
    queue_command(command(CMD_ADD_TRANS, 0, 0, 0, 1, 0, 0));
    queue_command(command(CMD_RESTART, 0, 0, 0, 0, 0, 0));
    wait_idle();

    run_random(4'd0, 5'd16, 5'd16, 1'b0, 325);
    run_random(4'd5, 5'd8, 5'd4, 1'b1, 325);
    run_random(4'd15, 5'd16, 5'd16, 1'b0, 325);
    run_random(4'd1, 5'd1, 5'd1, 1'b0, 325);
    run_random(4'd3, 5'd16, 5'd2, 1'b1, 325);
    run_random(4'd0, 5'd16, 5'd16, 1'b0, 325);

    if (engine_outcomes.size() != 0) begin
      mismatches += engine_outcomes.size();
      $display("%0d expected results never arrived", engine_outcomes.size());
    end
    $display("Covered %0d commands and %0d checked results under seven register settings.",
             commands_taken, results_checked);
    $display("%0d transitions followed, %0d real state changes, %0d rejected commands.",
             followed, state_changes, rejected);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
